/* src/cylindrical_unwrap_projection_defines.svh */
// Assertion macros for the cylindrical unwrap projection block
`ifndef CYLINDRICAL_UNWRAP_PROJECTION_DEFINES_SVH
`define CYLINDRICAL_UNWRAP_PROJECTION_DEFINES_SVH
`ifndef SYNTH
`define CUP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cup: same-cycle check failed");
`define CUP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cup: next-cycle check failed");
`else
`define CUP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CUP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/cup_pkg.sv */
// Types, constants and arctangent table for the cylindrical unwrap projection
`timescale 1ns / 1ps
package cup_pkg;

    localparam int COORD_W   = 32;
    localparam int RAD_W     = 25;
    localparam int CX_W      = 35;   // CORDIC x/y datapath, covers gain and fold
    localparam int ANG_W     = 32;   // angle, Q28 radians
    localparam int ROM_SIZE  = 32;
    localparam int CORDIC_STEPS_DEF = 20;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 25'd5833;
    localparam logic signed [ANG_W-1:0] PI_Q28 = 32'sd843314857;

    // atan(2^-i) in Q28, rounded
    localparam logic signed [ANG_W-1:0] ATAN_ROM [ROM_SIZE] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32,
        32'sd16,        32'sd8,         32'sd4,        32'sd2,
        32'sd1,         32'sd1,         32'sd0,        32'sd0
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_arc;
    } t_out_item;

    // what one cell hands to the next
    typedef struct packed {
        logic                      valid;
        logic                      zero;     // origin point, angle forced to 0
        logic signed [COORD_W-1:0] px;       // x coordinate carried along
        logic signed [CX_W-1:0]    x;
        logic signed [CX_W-1:0]    y;
        logic signed [ANG_W-1:0]   a;
    } t_cell;

endpackage

/* src/cup_cordic_cell.sv */
// One CORDIC vectoring micro-rotation with its pipeline register
`timescale 1ns / 1ps
module cup_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  cup_pkg::t_cell i_cell,
    output cup_pkg::t_cell o_cell
);

    cup_pkg::t_cell r_cell;
    cup_pkg::t_cell n_cell;
    logic signed [cup_pkg::CX_W-1:0] w_dx;
    logic signed [cup_pkg::CX_W-1:0] w_dy;

    assign w_dx = i_cell.y >>> STEP;
    assign w_dy = i_cell.x >>> STEP;

    always_comb begin
        n_cell = i_cell;
        if (i_cell.y[cup_pkg::CX_W-1]) begin
            n_cell.x = i_cell.x - w_dx;
            n_cell.y = i_cell.y + w_dy;
            n_cell.a = i_cell.a - cup_pkg::ATAN_ROM[STEP];
        end else begin
            n_cell.x = i_cell.x + w_dx;
            n_cell.y = i_cell.y - w_dy;
            n_cell.a = i_cell.a + cup_pkg::ATAN_ROM[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

/* src/cup_arc_scale.sv */
// Radius multiply, rounding, saturation and output register
`timescale 1ns / 1ps
module cup_arc_scale (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  cup_pkg::t_cell             i_cell,
    input  logic [cup_pkg::RAD_W-1:0]  i_radius,
    output logic                       o_valid,
    output cup_pkg::t_out_item         o_out
);

    localparam int PROD_W = cup_pkg::RAD_W + 1 + cup_pkg::ANG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(64'sd134217728);
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

    logic                                 r_pvalid;
    logic signed [PROD_W-1:0]             r_prod;
    logic signed [cup_pkg::COORD_W-1:0]   r_px;
    logic signed [cup_pkg::ANG_W-1:0]     w_theta;
    logic signed [SUM_W-1:0]              w_sum;
    logic signed [SUM_W-1:0]              w_shift;
    logic signed [cup_pkg::COORD_W-1:0]   w_arc;
    logic                                 r_valid;
    cup_pkg::t_out_item                   r_out;

    assign w_theta = i_cell.zero ? '0 : i_cell.a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else if (i_en) begin
            r_pvalid <= i_cell.valid;
            r_prod   <= $signed({1'b0, i_radius}) * w_theta;
            r_px     <= i_cell.px;
        end
    end

    // -prod rounded half up, then back to Q16.16
    assign w_sum   = HALF - {r_prod[PROD_W-1], r_prod};
    assign w_shift = w_sum >>> 28;

    always_comb begin
        if (w_shift > SAT_MAX) begin
            w_arc = SAT_MAX[cup_pkg::COORD_W-1:0];
        end else if (w_shift < SAT_MIN) begin
            w_arc = SAT_MIN[cup_pkg::COORD_W-1:0];
        end else begin
            w_arc = w_shift[cup_pkg::COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid       <= r_pvalid;
            r_out.out_x   <= r_px;
            r_out.out_arc <= w_arc;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

/* src/cylindrical_unwrap_projection.sv */
// Top level: quadrant fold, CORDIC cell chain and arc scaling
//
// Input channel i_valid/o_ready carries one point (coord_x, coord_y, coord_z),
// signed Q16.16. Output channel o_valid/i_ready carries out_x (coord_x as
// given) and out_arc = -radius * atan2(coord_z, coord_y), Q16.16, rounded
// and saturated. radius is written through i_cfg_we/i_cfg_wdata; the user
// must write it only at an edge where the block holds no request, which
// the block itself does not enforce. The pipeline holds one fold stage,
// one cell per CORDIC step (steps capped at 32), the multiply stage and
// the output register. Unless the output stalls, a new point is taken
// every cycle; throughput is one point per cycle, set by the cell chain.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_ready falls until i_ready returns.
// Reset (synchronous, active low) empties the pipeline and sets radius to
// 5833 (about 0.089). No clearing pass is needed.
`timescale 1ns / 1ps
`include "cylindrical_unwrap_projection_defines.svh"
module cylindrical_unwrap_projection #(
    parameter int CORDIC_STEPS = cup_pkg::CORDIC_STEPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  cup_pkg::t_in_item          i_in,
    output logic                       o_valid,
    input  logic                       i_ready,
    output cup_pkg::t_out_item         o_out,
    input  logic                       i_cfg_we,
    input  logic [cup_pkg::RAD_W-1:0]  i_cfg_wdata
);

    // the angle table ends at 32 entries, so the chain does too
    localparam int N_CELLS = (CORDIC_STEPS > cup_pkg::ROM_SIZE) ? cup_pkg::ROM_SIZE
                                                                : CORDIC_STEPS;
    localparam int XMSB    = cup_pkg::CX_W - 1;

    logic                          w_en;
    logic [cup_pkg::RAD_W-1:0]     r_radius;
    cup_pkg::t_cell                r_prep;
    cup_pkg::t_cell                n_prep;
    cup_pkg::t_cell                w_chain [N_CELLS+1];
    cup_pkg::t_cell                w_tail;
    logic signed [cup_pkg::CX_W-1:0] w_cy;
    logic signed [cup_pkg::CX_W-1:0] w_cz;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= cup_pkg::RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    assign w_cy = {{(cup_pkg::CX_W-cup_pkg::COORD_W){i_in.coord_y[cup_pkg::COORD_W-1]}},
                   i_in.coord_y};
    assign w_cz = {{(cup_pkg::CX_W-cup_pkg::COORD_W){i_in.coord_z[cup_pkg::COORD_W-1]}},
                   i_in.coord_z};

    // fold left half-plane onto the right, starting from +/-pi
    always_comb begin
        n_prep.valid = i_valid;
        n_prep.zero  = (i_in.coord_y == '0) && (i_in.coord_z == '0);
        n_prep.px    = i_in.coord_x;
        if (w_cy[cup_pkg::CX_W-1]) begin
            n_prep.x = -w_cy;
            n_prep.y = -w_cz;
            n_prep.a = w_cz[cup_pkg::CX_W-1] ? -cup_pkg::PI_Q28 : cup_pkg::PI_Q28;
        end else begin
            n_prep.x = w_cy;
            n_prep.y = w_cz;
            n_prep.a = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep.valid <= 1'b0;
        end else if (w_en) begin
            r_prep <= n_prep;
        end
    end

    assign w_chain[0] = r_prep;

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        cup_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    assign w_tail = w_chain[N_CELLS];

    cup_arc_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_cell   (w_tail),
        .i_radius (r_radius),
        .o_valid  (o_valid),
        .o_out    (o_out)
    );

    `CUP_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready, r_prep.valid)
    `CUP_ASSERT_IMP(a_fold_right, i_clk, i_rst_n, r_prep.valid && !r_prep.zero, !r_prep.x[XMSB])
    `CUP_ASSERT_IMP(a_chain_x_pos, i_clk, i_rst_n, w_tail.valid && !w_tail.zero, !w_tail.x[XMSB])

endmodule
